@@ rtl/core/tfn_pkg.sv @@
`timescale 1ns / 1ps
package tfn_pkg;
  localparam int COORD_BITS = 16;
  localparam int SCALE = 1024;
  localparam int INDEX_W = 16;
  localparam int OUT_W = 12;
  localparam int OUT_MAX = 2047;
  localparam int OUT_MIN_MAG = 2048;
  localparam int EDGE_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W = 2 * COORD_BITS + 1;
  localparam int SQ_W = 2 * MAG_W;
  localparam int SUM_W = SQ_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W = ROOT_W + 2;
  localparam int QBITS = $clog2(SCALE + 1);
  localparam int SCALE_W = $clog2(SCALE + 1);
  localparam int NUM_W = MAG_W + SCALE_W;
  localparam int DREM_W = ROOT_W + 1;
  localparam int EXT_W = ((QBITS > OUT_W) ? QBITS : OUT_W) + 1;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [2:0] neg;
    logic [2:0][MAG_W-1:0] mag;
  } side_t;

  typedef struct packed {
    logic [SUM_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [QBITS-1:0] lo;
    logic [QBITS-1:0] q;
  } quot_t;

  typedef struct packed {
    logic [ROOT_W-1:0] len;
    logic [2:0] neg;
    logic [INDEX_W-1:0] index;
    quot_t [2:0] c;
  } div_t;
endpackage

@@ rtl/core/triangle_face_normal.sv @@
`timescale 1ns / 1ps
// Flat face normal of one triangle, scaled so that a unit vector reads as 1024.
// The input channel (in_valid, in_ready) carries one triangle per word: the
// first vertex index and three signed vertex positions. The output channel
// (out_valid, out_ready) returns one word per triangle: the index and the
// three normal components, truncated toward zero; a degenerate triangle
// gives a zero normal.
// The datapath is a single pipeline of 52 stages: five for edges, products,
// cross product, squares and their sum, one cell per root bit of the square
// root (34), one setup stage, one cell per quotient bit of the divide (11)
// and the output register. A new word is taken every cycle while the output
// is not stalled.
// When the receiver holds out_ready low with a word waiting, the whole
// pipeline freezes and in_ready drops until that word is taken; no word is
// lost or repeated. Reset clears all valid flags, so the block comes up
// empty and ready.
module triangle_face_normal import tfn_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [INDEX_W-1:0] target_index,
  input  logic signed [COORD_BITS-1:0] first_x,
  input  logic signed [COORD_BITS-1:0] first_y,
  input  logic signed [COORD_BITS-1:0] first_z,
  input  logic signed [COORD_BITS-1:0] second_x,
  input  logic signed [COORD_BITS-1:0] second_y,
  input  logic signed [COORD_BITS-1:0] second_z,
  input  logic signed [COORD_BITS-1:0] third_x,
  input  logic signed [COORD_BITS-1:0] third_y,
  input  logic signed [COORD_BITS-1:0] third_z,
  output logic out_valid,
  input  logic out_ready,
  output logic [INDEX_W-1:0] result_index,
  output logic signed [OUT_W-1:0] normal_x,
  output logic signed [OUT_W-1:0] normal_y,
  output logic signed [OUT_W-1:0] normal_z
);
  logic adv;
  logic front_valid;
  side_t front_side;
  logic [SUM_W-1:0] front_sum;
  logic [ROOT_W:0] sq_vld;
  sqrt_t [ROOT_W:0] sq_data;
  side_t [ROOT_W:0] sq_side;
  logic [QBITS:0] dv_vld;
  div_t [QBITS:0] dv_data;
  logic [NUM_W-1:0] num [3];
  logic [OUT_W-1:0] nrm [3];
  logic [EXT_W-1:0] qe;

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  tfn_front u_front (
    .clk, .rst, .adv, .in_valid, .target_index,
    .first_x, .first_y, .first_z, .second_x, .second_y, .second_z,
    .third_x, .third_y, .third_z,
    .out_valid(front_valid), .side(front_side), .sum(front_sum)
  );

  assign sq_vld[0] = front_valid;
  assign sq_data[0] = '{rad: front_sum, rem: '0, root: '0};
  assign sq_side[0] = front_side;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    tfn_sqrt_cell u_cell (
      .clk, .rst, .adv,
      .in_valid(sq_vld[k]), .in_data(sq_data[k]), .in_side(sq_side[k]),
      .out_valid(sq_vld[k+1]), .out_data(sq_data[k+1]), .out_side(sq_side[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (adv) begin
      dv_vld[0] <= sq_vld[ROOT_W];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = NUM_W'(sq_side[ROOT_W].mag[i]) * NUM_W'(SCALE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_data[0].len <= (sq_data[ROOT_W].root == '0) ? ROOT_W'(1) : sq_data[ROOT_W].root;
      dv_data[0].neg <= sq_side[ROOT_W].neg;
      dv_data[0].index <= sq_side[ROOT_W].index;
      for (int i = 0; i < 3; i++) begin
        dv_data[0].c[i].rem <= DREM_W'(num[i][NUM_W-1:QBITS]);
        dv_data[0].c[i].lo <= num[i][QBITS-1:0];
        dv_data[0].c[i].q <= '0;
      end
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_div
    tfn_div_cell u_cell (
      .clk, .rst, .adv,
      .in_valid(dv_vld[k]), .in_data(dv_data[k]),
      .out_valid(dv_vld[k+1]), .out_data(dv_data[k+1])
    );
  end

  always_comb begin
    qe = '0;
    for (int i = 0; i < 3; i++) begin
      qe = EXT_W'(dv_data[QBITS].c[i].q);
      if (dv_data[QBITS].neg[i]) begin
        nrm[i] = (qe > EXT_W'(OUT_MIN_MAG)) ? OUT_W'(OUT_MIN_MAG) : OUT_W'(-qe);
      end else begin
        nrm[i] = (qe > EXT_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(qe);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_vld[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_index <= dv_data[QBITS].index;
      normal_x <= nrm[0];
      normal_y <= nrm[1];
      normal_z <= nrm[2];
    end
  end
endmodule

@@ rtl/core/tfn_front.sv @@
`timescale 1ns / 1ps
module tfn_front import tfn_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  logic [INDEX_W-1:0] target_index,
  input  logic signed [COORD_BITS-1:0] first_x,
  input  logic signed [COORD_BITS-1:0] first_y,
  input  logic signed [COORD_BITS-1:0] first_z,
  input  logic signed [COORD_BITS-1:0] second_x,
  input  logic signed [COORD_BITS-1:0] second_y,
  input  logic signed [COORD_BITS-1:0] second_z,
  input  logic signed [COORD_BITS-1:0] third_x,
  input  logic signed [COORD_BITS-1:0] third_y,
  input  logic signed [COORD_BITS-1:0] third_z,
  output logic out_valid,
  output side_t side,
  output logic [SUM_W-1:0] sum
);
  logic [4:0] vld;
  logic [1:0][INDEX_W-1:0] idx;
  logic signed [EDGE_W-1:0] ux, uy, uz, vx, vy, vz;
  logic signed [PROD_W-1:0] p0, p1, p2, p3, p4, p5;
  logic signed [CROSS_W-1:0] cx, cy, cz;
  side_t s2, s3, s4;
  logic [2:0][SQ_W-1:0] sq;

  function automatic logic [MAG_W-1:0] abs_mag(input logic signed [CROSS_W-1:0] v);
    logic [CROSS_W-1:0] a;
    a = v[CROSS_W-1] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  always_comb begin
    cx = CROSS_W'(p0) - CROSS_W'(p1);
    cy = CROSS_W'(p2) - CROSS_W'(p3);
    cz = CROSS_W'(p4) - CROSS_W'(p5);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx <= {idx[0], target_index};
      ux <= EDGE_W'(second_x) - EDGE_W'(first_x);
      uy <= EDGE_W'(second_y) - EDGE_W'(first_y);
      uz <= EDGE_W'(second_z) - EDGE_W'(first_z);
      vx <= EDGE_W'(third_x) - EDGE_W'(first_x);
      vy <= EDGE_W'(third_y) - EDGE_W'(first_y);
      vz <= EDGE_W'(third_z) - EDGE_W'(first_z);
      p0 <= uy * vz;
      p1 <= uz * vy;
      p2 <= uz * vx;
      p3 <= ux * vz;
      p4 <= ux * vy;
      p5 <= uy * vx;
      s2.index <= idx[1];
      s2.neg <= {cz[CROSS_W-1], cy[CROSS_W-1], cx[CROSS_W-1]};
      s2.mag <= {abs_mag(cz), abs_mag(cy), abs_mag(cx)};
      for (int i = 0; i < 3; i++) begin
        sq[i] <= SQ_W'(s2.mag[i]) * SQ_W'(s2.mag[i]);
      end
      s3 <= s2;
      sum <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
      s4 <= s3;
    end
  end

  assign out_valid = vld[4];
  assign side = s4;
endmodule

@@ rtl/core/tfn_sqrt_cell.sv @@
`timescale 1ns / 1ps
module tfn_sqrt_cell import tfn_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  sqrt_t in_data,
  input  side_t in_side,
  output logic out_valid,
  output sqrt_t out_data,
  output side_t out_side
);
  logic [REM_W-1:0] rem_s, trial;
  logic ge;

  always_comb begin
    rem_s = {in_data.rem[REM_W-3:0], in_data.rad[SUM_W-1:SUM_W-2]};
    trial = {in_data.root, 2'b01};
    ge = rem_s >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.rad <= {in_data.rad[SUM_W-3:0], 2'b00};
      out_data.rem <= ge ? rem_s - trial : rem_s;
      out_data.root <= {in_data.root[ROOT_W-2:0], ge};
      out_side <= in_side;
    end
  end
endmodule

@@ rtl/core/tfn_div_cell.sv @@
`timescale 1ns / 1ps
module tfn_div_cell import tfn_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  div_t in_data,
  output logic out_valid,
  output div_t out_data
);
  logic [2:0][DREM_W-1:0] rem_s;
  logic [2:0] ge;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_s[i] = {in_data.c[i].rem[DREM_W-2:0], in_data.c[i].lo[QBITS-1]};
      ge[i] = rem_s[i] >= {1'b0, in_data.len};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.len <= in_data.len;
      out_data.neg <= in_data.neg;
      out_data.index <= in_data.index;
      for (int i = 0; i < 3; i++) begin
        out_data.c[i].rem <= ge[i] ? rem_s[i] - {1'b0, in_data.len} : rem_s[i];
        out_data.c[i].lo <= {in_data.c[i].lo[QBITS-2:0], 1'b0};
        out_data.c[i].q <= {in_data.c[i].q[QBITS-2:0], ge[i]};
      end
    end
  end
endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import tfn_pkg::*;

  typedef struct {
    logic [INDEX_W-1:0] index;
    logic signed [COORD_BITS-1:0] c [9];
  } triangle_t;

  typedef struct {
    logic [INDEX_W-1:0] index;
    logic signed [OUT_W-1:0] n [3];
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [INDEX_W-1:0] target_index = '0;
  logic signed [COORD_BITS-1:0] first_x = '0, first_y = '0, first_z = '0;
  logic signed [COORD_BITS-1:0] second_x = '0, second_y = '0, second_z = '0;
  logic signed [COORD_BITS-1:0] third_x = '0, third_y = '0, third_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [INDEX_W-1:0] result_index;
  logic signed [OUT_W-1:0] normal_x, normal_y, normal_z;

  triangle_face_normal DUT (.*);

  triangle_t pending_triangles [$];
  normal_t expected_normals [$];
  int send_idle_pct = 33;
  int recv_idle_pct = 46;
  int mismatches = 0;
  int normals_seen = 0;
  int quiet_cycles = 0;
  bit stimulus_done = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic signed [OUT_W-1:0] scaled_part(
      logic signed [127:0] comp, logic [127:0] len);
    logic [127:0] mag;
    logic signed [127:0] q;
    mag = comp < 0 ? -comp : comp;
    q = (mag * SCALE) / len;
    if (comp < 0) q = -q;
    if (q > OUT_MAX) q = OUT_MAX;
    if (q < -OUT_MIN_MAG) q = -OUT_MIN_MAG;
    return q[OUT_W-1:0];
  endfunction

  function automatic normal_t face_normal(triangle_t t);
    logic signed [127:0] u [3];
    logic signed [127:0] v [3];
    logic signed [127:0] n [3];
    logic [127:0] sum, root, bitv;
    normal_t r;
    for (int i = 0; i < 3; i++) begin
      u[i] = 128'(t.c[3 + i]) - 128'(t.c[i]);
      v[i] = 128'(t.c[6 + i]) - 128'(t.c[i]);
    end
    n[0] = u[1] * v[2] - u[2] * v[1];
    n[1] = u[2] * v[0] - u[0] * v[2];
    n[2] = u[0] * v[1] - u[1] * v[0];
    sum = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
    root = 0;
    for (int k = 63; k >= 0; k--) begin
      bitv = root | (128'd1 << k);
      if (bitv * bitv <= sum) root = bitv;
    end
    if (root == 0) root = 1;
    r.index = t.index;
    for (int i = 0; i < 3; i++) r.n[i] = scaled_part(n[i], root);
    return r;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] rand_coord(int spread);
    case (spread)
      0: return $urandom;
      1: return $urandom_range(0, 200) - 100;
      2: return $urandom_range(0, 1) ? 16'sh7fff - $urandom_range(0, 3)
                                     : 16'sh8000 + $urandom_range(0, 3);
      default: return $urandom_range(0, 8000) - 4000;
    endcase
  endfunction

  task automatic add_triangle(triangle_t t);
    pending_triangles.push_back(t);
  endtask

  initial begin
    triangle_t t;
    logic signed [COORD_BITS-1:0] ext [2];
    ext[0] = 16'sh7fff;
    ext[1] = 16'sh8000;
    t.index = 16'hffff;
    for (int i = 0; i < 9; i++) t.c[i] = 0;
    add_triangle(t);
    t.index = 0;
    for (int i = 0; i < 9; i++) t.c[i] = 5;
    add_triangle(t);
    for (int m = 0; m < 8; m++) begin
      t.index = m;
      for (int i = 0; i < 9; i++) t.c[i] = ext[(m >> (i % 3)) & 1 ^ (i / 3 == 1)];
      t.c[0] = ext[m & 1];
      add_triangle(t);
    end
    t.index = 16'h5555;
    t.c = '{0, 0, 0, 16'sh7fff, 0, 0, 0, 16'sh7fff, 0};
    add_triangle(t);
    t.c = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
            16'sh8000, 16'sh7fff, 16'sh8000};
    add_triangle(t);
    t.c = '{1, 2, 3, 2, 4, 6, 3, 6, 9};
    add_triangle(t);
    t.c = '{0, 0, 0, 0, 0, 1, 0, 1, 0};
    add_triangle(t);
    t.index = 16'haaaa;
    t.c = '{0, 0, 0, 1, 0, 0, 0, 0, 1};
    add_triangle(t);
    t.c = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
            16'sh7fff, 16'sh7fff, 16'sh8000};
    add_triangle(t);
    for (int k = 0; k < 500; k++) begin
      int spread;
      spread = $urandom_range(0, 3);
      t.index = $urandom;
      for (int i = 0; i < 9; i++) t.c[i] = rand_coord(spread);
      if ($urandom_range(0, 19) == 0) begin
        for (int i = 3; i < 9; i++) t.c[i] = t.c[i % 3] + (i / 3 == 1 ? 1 : 2) * t.c[i % 3 ^ 1];
      end
      add_triangle(t);
      if (k == 170) begin
        wait (pending_triangles.size() == 0);
        send_idle_pct = 46;
        recv_idle_pct = 33;
      end else if (k == 340) begin
        wait (pending_triangles.size() == 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end
    wait (pending_triangles.size() == 0 && !in_valid);
    stimulus_done = 1'b1;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_triangles.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        triangle_t t;
        t = pending_triangles.pop_front();
        expected_normals.push_back(face_normal(t));
        target_index <= t.index;
        {first_x, first_y, first_z} <= {t.c[0], t.c[1], t.c[2]};
        {second_x, second_y, second_z} <= {t.c[3], t.c[4], t.c[5]};
        {third_x, third_y, third_z} <= {t.c[6], t.c[7], t.c[8]};
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && out_ready) begin
        normals_seen <= normals_seen + 1;
        if (expected_normals.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected word, index %0d", result_index);
        end else begin
          normal_t e;
          e = expected_normals.pop_front();
          if (e.index !== result_index || e.n[0] !== normal_x ||
              e.n[1] !== normal_y || e.n[2] !== normal_z) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected %0d (%0d %0d %0d), got %0d (%0d %0d %0d)",
                       e.index, e.n[0], e.n[1], e.n[2],
                       result_index, normal_x, normal_y, normal_z);
          end
        end
      end
      out_ready <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    fork
      begin
        wait (stimulus_done && expected_normals.size() == 0);
        repeat (120) @(posedge clk);
      end
      wait (quiet_cycles >= 5000);
    join_any
    if (quiet_cycles >= 5000) begin
      $display("Watchdog expired with %0d words outstanding", expected_normals.size());
      $display("TB_ERROR");
    end else begin
      $display("Checked %0d face normals, including degenerate and extreme triangles,",
               normals_seen);
      $display("under sender and receiver stalls; %0d mismatches.", mismatches);
      if (mismatches == 0 && expected_normals.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
    end
    $finish;
  end
endmodule

@@ triangle_face_normal.f @@
rtl/core/tfn_pkg.sv
rtl/core/tfn_front.sv
rtl/core/tfn_sqrt_cell.sv
rtl/core/tfn_div_cell.sv
rtl/core/triangle_face_normal.sv
sim/testbench.sv
